>>> rtl/core/mtd_pkg.sv
`timescale 1ns / 1ps
// Package for the multitouch slot event decoder: sizes, event codes,
// configuration register indexes. No dependencies.
package mtd_pkg;

  localparam int FINGER_SLOTS   = 10;
  localparam int RAW_COORD_BITS = 16;

  localparam int SLOT_W     = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;
  localparam int TYPE_W     = 5;
  localparam int CODE_W     = 10;
  localparam int VALUE_W    = 32;
  localparam int PIX_W      = 14;
  localparam int GAIN_W     = 24;
  localparam int DIM_W      = 14;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W     = RAW_COORD_BITS + GAIN_W;
  localparam int MAP_W      = PROD_W + 2;

  localparam logic [RAW_COORD_BITS-1:0] RAW_MAX = '1;
  localparam logic [PIX_W-1:0]          PIX_MAX = '1;

  // event classes and axis codes
  localparam logic [TYPE_W-1:0] EV_SYNC = 5'd0;
  localparam logic [TYPE_W-1:0] EV_ABS  = 5'd3;

  localparam logic [CODE_W-1:0] CODE_SYNC_REPORT = 10'd0;
  localparam logic [CODE_W-1:0] CODE_SLOT        = 10'd47;
  localparam logic [CODE_W-1:0] CODE_POS_X       = 10'd53;
  localparam logic [CODE_W-1:0] CODE_POS_Y       = 10'd54;
  localparam logic [CODE_W-1:0] CODE_TRACK_ID    = 10'd57;

  localparam logic signed [VALUE_W-1:0] TRACK_LIFT = -32'sd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_LONG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_SHORT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_MAPPING  = 3'd5;

  typedef logic [RAW_COORD_BITS-1:0] raw_t;
  typedef logic [PIX_W-1:0]          pix_t;
  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [PROD_W-1:0]         prod_t;

endpackage

>>> rtl/core/mtd_evt_if.sv
`timescale 1ns / 1ps
// Input event channel: valid/ready plus one event word.
// Depends on mtd_pkg.
interface mtd_evt_if;
  logic                                    valid;
  logic                                    ready;
  logic [mtd_pkg::TYPE_W-1:0]              event_type;
  logic [mtd_pkg::CODE_W-1:0]              event_code;
  logic signed [mtd_pkg::VALUE_W-1:0]      event_value;

  modport source (output valid, event_type, event_code, event_value, input ready);
  modport sink   (input valid, event_type, event_code, event_value, output ready);
endinterface

>>> rtl/core/mtd_ptr_if.sv
`timescale 1ns / 1ps
// Pointer report channel: valid/ready plus one report word.
// Depends on mtd_pkg.
interface mtd_ptr_if;
  logic                        valid;
  logic                        ready;
  logic                        pointer_down;
  logic [mtd_pkg::PIX_W-1:0]   pointer_x;
  logic [mtd_pkg::PIX_W-1:0]   pointer_y;

  modport source (output valid, pointer_down, pointer_x, pointer_y, input ready);
  modport sink   (input valid, pointer_down, pointer_x, pointer_y, output ready);
endinterface

>>> rtl/core/multitouch_slot_event_decoder_core.sv
`timescale 1ns / 1ps
// Multitouch slot event decoder (protocol type B), top level.
// Depends on mtd_pkg, mtd_evt_if, mtd_ptr_if, mtd_ram.
//
// evt_i takes one input event word per cycle (valid/ready). Slot, tracking-id
// and X/Y events update state at the edge they are accepted and give no word.
// A sync report (type sync, code sync report) gives exactly one word on ptr_o:
// the screen position of the lowest-numbered down finger, or pointer_down 0
// and the last reported position.
// A sync report passes the raw position RAM read, gain multiply, and map and
// saturate stages before ptr_o. Throughput is one event per cycle while ready
// is high; the raw X/Y RAMs take one write and one read per cycle.
// If ptr_o stalls, the three-stage pipe fills and evt_i.ready drops only once
// every stage holds a word; empty stages are squeezed out.
// Reset clears current slot, finger flags, written-marks of the raw RAMs, the
// last position and the configuration registers to their defaults; no
// clearing pass is needed. Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) must
// be written by the user only while no sync report is in flight (not enforced).
module multitouch_slot_event_decoder_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mtd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mtd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  mtd_evt_if.sink                            evt_i,
  mtd_ptr_if.source                          ptr_o
);
  import mtd_pkg::*;

  // configuration
  logic [GAIN_W-1:0] x_gain_q, y_gain_q;
  logic [DIM_W-1:0]  scr_long_q, scr_short_q;
  logic [1:0]        rot_q;
  logic              alt_q;

  // slot state
  slot_t                   cur_slot_q;
  logic [FINGER_SLOTS-1:0] down_q, x_vld_q, y_vld_q;

  // pipeline
  logic  s1_v_q, s1_down_q, s1_xv_q, s1_yv_q;
  logic  s2_v_q, s2_down_q;
  prod_t s2_xt_q, s2_yt_q;
  logic  out_v_q, out_down_q;
  pix_t  out_x_q, out_y_q, last_x_q, last_y_q;

  logic  take, s2_free, s1_free;
  logic  evt_acc, is_abs, is_sync;
  logic  wr_x, wr_y, rd_en;
  slot_t first_idx;
  logic  any_down;
  slot_t slot_val;
  raw_t  raw_val;
  raw_t  rx_rdata, ry_rdata, rx_op, ry_op;
  pix_t  map_x, map_y;

  assign take    = !out_v_q || ptr_o.ready;
  assign s2_free = !s2_v_q || take;
  assign s1_free = !s1_v_q || s2_free;

  assign evt_i.ready = s1_free;
  assign evt_acc = evt_i.valid && evt_i.ready;
  assign is_abs  = evt_i.event_type == EV_ABS;
  assign is_sync = (evt_i.event_type == EV_SYNC) && (evt_i.event_code == CODE_SYNC_REPORT);

  assign wr_x  = evt_acc && is_abs && (evt_i.event_code == CODE_POS_X);
  assign wr_y  = evt_acc && is_abs && (evt_i.event_code == CODE_POS_Y);
  assign rd_en = evt_acc && is_sync;

  // lowest-numbered down finger
  always_comb begin
    first_idx = '0;
    any_down  = 1'b0;
    for (int i = FINGER_SLOTS - 1; i >= 0; i--) begin
      if (down_q[i]) begin
        first_idx = SLOT_W'(i);
        any_down  = 1'b1;
      end
    end
  end

  // slot select clamps to 0..FINGER_SLOTS-1
  always_comb begin
    if (evt_i.event_value[VALUE_W-1]) begin
      slot_val = '0;
    end else if (evt_i.event_value > $signed(VALUE_W'(FINGER_SLOTS - 1))) begin
      slot_val = SLOT_W'(FINGER_SLOTS - 1);
    end else begin
      slot_val = evt_i.event_value[SLOT_W-1:0];
    end
  end

  // raw coordinate saturates to 0..RAW_MAX
  always_comb begin
    if (evt_i.event_value[VALUE_W-1]) begin
      raw_val = '0;
    end else if (|evt_i.event_value[VALUE_W-2:RAW_COORD_BITS]) begin
      raw_val = RAW_MAX;
    end else begin
      raw_val = evt_i.event_value[RAW_COORD_BITS-1:0];
    end
  end

  mtd_ram #(.WIDTH(RAW_COORD_BITS), .DEPTH(FINGER_SLOTS)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (wr_x),
    .waddr_i (cur_slot_q),
    .wdata_i (raw_val),
    .re_i    (rd_en),
    .raddr_i (first_idx),
    .rdata_o (rx_rdata)
  );

  mtd_ram #(.WIDTH(RAW_COORD_BITS), .DEPTH(FINGER_SLOTS)) u_ry_ram (
    .clk_i   (clk_i),
    .we_i    (wr_y),
    .waddr_i (cur_slot_q),
    .wdata_i (raw_val),
    .re_i    (rd_en),
    .raddr_i (first_idx),
    .rdata_o (ry_rdata)
  );

  // never-written entries read as zero
  assign rx_op = s1_xv_q ? rx_rdata : '0;
  assign ry_op = s1_yv_q ? ry_rdata : '0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_gain_q    <= GAIN_W'(65536);
      y_gain_q    <= GAIN_W'(65536);
      scr_long_q  <= DIM_W'(1920);
      scr_short_q <= DIM_W'(1080);
      rot_q       <= 2'd0;
      alt_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_X_GAIN:       x_gain_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_Y_GAIN:       y_gain_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_SCREEN_LONG:  scr_long_q  <= cfg_data_i[DIM_W-1:0];
        CFG_SCREEN_SHORT: scr_short_q <= cfg_data_i[DIM_W-1:0];
        CFG_ROTATION:     rot_q       <= cfg_data_i[1:0];
        CFG_ALT_MAPPING:  alt_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // slot state update at accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_slot_q <= '0;
      down_q     <= '0;
      x_vld_q    <= '0;
      y_vld_q    <= '0;
    end else if (evt_acc && is_abs) begin
      unique case (evt_i.event_code)
        CODE_SLOT:     cur_slot_q          <= slot_val;
        CODE_TRACK_ID: down_q[cur_slot_q]  <= (evt_i.event_value != TRACK_LIFT);
        CODE_POS_X:    x_vld_q[cur_slot_q] <= 1'b1;
        CODE_POS_Y:    y_vld_q[cur_slot_q] <= 1'b1;
        default: ;
      endcase
    end
  end

  // map one point: Q.16 gain products, orientation, truncate and saturate
  function automatic pix_t to_pixel(logic signed [MAP_W-1:0] v);
    pix_t p;
    if (v[MAP_W-1]) begin
      p = '0;
    end else if (|v[MAP_W-2:FRAC_W+PIX_W]) begin
      p = PIX_MAX;
    end else begin
      p = v[FRAC_W+PIX_W-1:FRAC_W];
    end
    return p;
  endfunction

  always_comb begin
    logic signed [MAP_W-1:0] xt, yt, lq, sq, mx, my;
    xt = $signed({2'b00, s2_xt_q});
    yt = $signed({2'b00, s2_yt_q});
    lq = $signed(MAP_W'({scr_long_q, FRAC_W'(0)}));
    sq = $signed(MAP_W'({scr_short_q, FRAC_W'(0)}));
    case ({alt_q, rot_q})
      3'b001:  begin mx = yt;      my = sq - xt; end
      3'b010:  begin mx = sq - xt; my = lq - yt; end
      3'b011:  begin mx = lq - yt; my = xt;      end
      3'b100:  begin mx = sq - yt; my = xt;      end
      3'b101:  begin mx = xt;      my = yt;      end
      3'b110:  begin mx = sq - xt; my = yt;      end
      3'b111:  begin mx = sq - xt; my = lq - yt; end
      default: begin mx = xt;      my = yt;      end
    endcase
    map_x = to_pixel(mx);
    map_y = to_pixel(my);
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      last_x_q <= '0;
      last_y_q <= '0;
    end else begin
      if (s1_free) begin
        s1_v_q <= rd_en;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
      if (take) begin
        out_v_q <= s2_v_q;
        if (s2_v_q && s2_down_q) begin
          last_x_q <= map_x;
          last_y_q <= map_y;
        end
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (s1_free && rd_en) begin
      s1_down_q <= any_down;
      s1_xv_q   <= x_vld_q[first_idx];
      s1_yv_q   <= y_vld_q[first_idx];
    end
    if (s2_free && s1_v_q) begin
      s2_down_q <= s1_down_q;
      s2_xt_q   <= PROD_W'(rx_op) * PROD_W'(x_gain_q);
      s2_yt_q   <= PROD_W'(ry_op) * PROD_W'(y_gain_q);
    end
    if (take && s2_v_q) begin
      out_down_q <= s2_down_q;
      out_x_q    <= s2_down_q ? map_x : last_x_q;
      out_y_q    <= s2_down_q ? map_y : last_y_q;
    end
  end

  assign ptr_o.valid        = out_v_q;
  assign ptr_o.pointer_down = out_down_q;
  assign ptr_o.pointer_x    = out_x_q;
  assign ptr_o.pointer_y    = out_y_q;

`ifndef NO_ASSERTIONS
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_slot_q <= SLOT_W'(FINGER_SLOTS - 1))
    else $error("current slot beyond last finger slot");

  a_sync_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> s1_v_q)
    else $error("accepted sync report lost before first stage");

  a_out_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_x_q == last_x_q && out_y_q == last_y_q))
    else $error("reported position differs from last position");

  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && !take |=> s2_v_q && $stable(s2_xt_q) && $stable(s2_yt_q))
    else $error("stalled product stage changed");
`endif

endmodule

>>> rtl/core/mtd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for multitouch_slot_event_decoder_core: directed and random event streams,
// a scoreboard class that predicts pointer reports and checks them word by word.
// Depends on mtd_pkg, mtd_evt_if, mtd_ptr_if and the decoder RTL.
module tb;
  import mtd_pkg::*;

  localparam int          RANDOM_ITEMS = 1350;
  localparam int          PHASES       = 12;
  localparam int          SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  localparam logic [TYPE_W-1:0]    EV_UNKNOWN      = 5'd31;
  localparam logic [CODE_W-1:0]    CODE_UNKNOWN    = 10'd1023;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;
  localparam logic [GAIN_W-1:0]    GAIN_ONE        = 24'd65536;
  localparam logic [GAIN_W-1:0]    GAIN_TOP        = '1;
  localparam logic [DIM_W-1:0]     DIM_TOP         = '1;

  typedef struct packed {
    logic down;
    pix_t x;
    pix_t y;
  } report_t;

  class pointer_report_checker;
    int unsigned x_gain, y_gain, scr_long, scr_short, rotation;
    bit          alt_map;
    int unsigned cur_slot;
    bit          touch_down[FINGER_SLOTS];
    raw_t        raw_x[FINGER_SLOTS];
    raw_t        raw_y[FINGER_SLOTS];
    pix_t        last_x, last_y;
    report_t     expected_reports[$];
    int          errors;

    function new();
      x_gain    = GAIN_ONE;
      y_gain    = GAIN_ONE;
      scr_long  = 1920;
      scr_short = 1080;
      rotation  = 0;
      alt_map   = 1'b0;
      cur_slot  = 0;
      for (int i = 0; i < FINGER_SLOTS; i++) begin
        touch_down[i] = 1'b0;
        raw_x[i]      = '0;
        raw_y[i]      = '0;
      end
      last_x = '0;
      last_y = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_X_GAIN:       x_gain    = data[GAIN_W-1:0];
        CFG_Y_GAIN:       y_gain    = data[GAIN_W-1:0];
        CFG_SCREEN_LONG:  scr_long  = data[DIM_W-1:0];
        CFG_SCREEN_SHORT: scr_short = data[DIM_W-1:0];
        CFG_ROTATION:     rotation  = data[1:0];
        CFG_ALT_MAPPING:  alt_map   = data[0];
        default: ;  // spare index, write dropped
      endcase
    endfunction

    function raw_t clamp_raw(logic signed [VALUE_W-1:0] v);
      longint lv;
      lv = v;
      if (lv < 0) return '0;
      if (lv > longint'(RAW_MAX)) return RAW_MAX;
      return v[RAW_COORD_BITS-1:0];
    endfunction

    // Q.16 to whole pixels, truncated, clipped to 0..PIX_MAX
    function pix_t to_pix(longint q);
      longint p;
      if (q < 0) return '0;
      p = q >>> FRAC_W;
      if (p > longint'(PIX_MAX)) return PIX_MAX;
      return p[PIX_W-1:0];
    endfunction

    function void map_to_screen(raw_t rx, raw_t ry, output pix_t px, output pix_t py);
      longint xt, yt, lq, sq, mx, my;
      xt = longint'(rx) * longint'(x_gain);
      yt = longint'(ry) * longint'(y_gain);
      lq = longint'(scr_long) << FRAC_W;
      sq = longint'(scr_short) << FRAC_W;
      if (alt_map) begin
        case (rotation)
          1: begin mx = xt;      my = yt;      end
          2: begin mx = sq - xt; my = yt;      end
          3: begin mx = sq - xt; my = lq - yt; end
          default: begin mx = sq - yt; my = xt; end
        endcase
      end else begin
        case (rotation)
          1: begin mx = yt;      my = sq - xt; end
          2: begin mx = sq - xt; my = lq - yt; end
          3: begin mx = lq - yt; my = xt;      end
          default: begin mx = xt; my = yt; end
        endcase
      end
      px = to_pix(mx);
      py = to_pix(my);
    endfunction

    function void note_event(logic [TYPE_W-1:0] etype, logic [CODE_W-1:0] ecode,
                             logic signed [VALUE_W-1:0] evalue);
      report_t r;
      int      first;
      if (etype == EV_ABS) begin
        if (ecode == CODE_SLOT) begin
          if (evalue < 0) cur_slot = 0;
          else if (evalue > FINGER_SLOTS - 1) cur_slot = FINGER_SLOTS - 1;
          else cur_slot = evalue;
        end else if (ecode == CODE_TRACK_ID) begin
          touch_down[cur_slot] = (evalue != TRACK_LIFT);
        end else if (ecode == CODE_POS_X) begin
          raw_x[cur_slot] = clamp_raw(evalue);
        end else if (ecode == CODE_POS_Y) begin
          raw_y[cur_slot] = clamp_raw(evalue);
        end
      end else if (etype == EV_SYNC && ecode == CODE_SYNC_REPORT) begin
        first = -1;
        for (int i = FINGER_SLOTS - 1; i >= 0; i--)
          if (touch_down[i]) first = i;
        if (first >= 0) map_to_screen(raw_x[first], raw_y[first], last_x, last_y);
        r.down = (first >= 0);
        r.x    = last_x;
        r.y    = last_y;
        expected_reports = {expected_reports, r};
      end
    endfunction

    function void check_report(logic down, pix_t x, pix_t y);
      report_t e;
      if (expected_reports.size() == 0) begin
        $error("unexpected pointer report: down %0d x %0d y %0d", down, x, y);
        errors++;
        return;
      end
      e = expected_reports.pop_front();
      if (down !== e.down) begin
        $error("pointer_down: expected %0d, actual %0d", e.down, down);
        errors++;
      end
      if (x !== e.x) begin
        $error("pointer_x: expected %0d, actual %0d", e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $error("pointer_y: expected %0d, actual %0d", e.y, y);
        errors++;
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  mtd_evt_if evt ();
  mtd_ptr_if ptr ();

  multitouch_slot_event_decoder_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .evt_i      (evt),
    .ptr_o      (ptr)
  );

  pointer_report_checker sb = new();

  int          src_idle_pct  = 0;
  int          snk_stall_pct = 0;
  int          items_sent    = 0;
  int unsigned cycle_count   = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    ptr.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // both channels sampled on the pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (evt.valid && evt.ready)
        sb.note_event(evt.event_type, evt.event_code, evt.event_value);
      if (ptr.valid && ptr.ready)
        sb.check_report(ptr.pointer_down, ptr.pointer_x, ptr.pointer_y);
    end
  end

  // valid stays high after acceptance; the next call lowers or reloads it
  task automatic send_event(input logic [TYPE_W-1:0] t, input logic [CODE_W-1:0] c,
                            input logic [VALUE_W-1:0] v, input bit counted);
    while ($urandom_range(99) < src_idle_pct) begin
      evt.valid <= 1'b0;
      @(posedge clk_i);
    end
    evt.valid       <= 1'b1;
    evt.event_type  <= t;
    evt.event_code  <= c;
    evt.event_value <= v;
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
    if (counted) items_sent++;
  endtask

  task automatic drain_reports();
    evt.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // back-to-back writes keep we high; it drops once after the batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return GAIN_TOP;
      2:       return GAIN_ONE;
      default: return GAIN_W'($urandom_range(1 << 17));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(3))
      0:       return DIM_W'(1);
      1:       return DIM_TOP;
      default: return DIM_W'($urandom_range(DIM_TOP, 1));
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_coord();
    case ($urandom_range(9))
      0, 1:    return $urandom();
      2, 3, 4: return $urandom_range(RAW_MAX);
      default: return $urandom_range(4095);
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_slot();
    case ($urandom_range(9))
      8:       return $urandom();
      9:       return $urandom_range(15, FINGER_SLOTS);
      default: return $urandom_range(FINGER_SLOTS - 1);
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_track();
    case ($urandom_range(9))
      0, 1, 2: return TRACK_LIFT;
      3:       return $urandom();
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic program_phase(input int ph);
    logic [GAIN_W-1:0] xg, yg;
    logic [DIM_W-1:0]  dl, ds;
    xg = pick_gain();
    yg = pick_gain();
    dl = pick_dim();
    ds = pick_dim();
    if (ph == 1) begin
      xg = '0;
      yg = '0;
      dl = DIM_W'(1);
      ds = DIM_W'(1);
    end else if (ph == 2) begin
      xg = GAIN_TOP;
      yg = GAIN_TOP;
      dl = DIM_TOP;
      ds = DIM_TOP;
    end
    write_reg(CFG_X_GAIN, xg);
    write_reg(CFG_Y_GAIN, yg);
    write_reg(CFG_SCREEN_LONG, CFG_DATA_W'(dl));
    write_reg(CFG_SCREEN_SHORT, CFG_DATA_W'(ds));
    write_reg(CFG_ROTATION, CFG_DATA_W'(ph % 4));
    write_reg(CFG_ALT_MAPPING, CFG_DATA_W'((ph / 4) % 2));
    cfg_we_i <= 1'b0;
    case ((ph + ph / 4) % 4)
      0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1:       begin src_idle_pct = 67; snk_stall_pct = 0;  end
      2:       begin src_idle_pct = 0;  snk_stall_pct = 67; end
      default: begin src_idle_pct = 10; snk_stall_pct = 10; end
    endcase
  endtask

  // one touch frame: per-finger slot/id/position words, then usually a sync
  task automatic send_frame();
    int nf;
    nf = $urandom_range(3);
    for (int f = 0; f < nf; f++) begin
      send_event(EV_ABS, CODE_SLOT, pick_slot(), 1'b1);
      if ($urandom_range(9) < 8) send_event(EV_ABS, CODE_TRACK_ID, pick_track(), 1'b1);
      if ($urandom_range(9) < 7) send_event(EV_ABS, CODE_POS_X, pick_coord(), 1'b1);
      if ($urandom_range(9) < 7) send_event(EV_ABS, CODE_POS_Y, pick_coord(), 1'b1);
      if ($urandom_range(9) == 0)
        send_event(TYPE_W'($urandom_range(31)), CODE_W'($urandom_range(1023)),
                   $urandom(), 1'b0);
    end
    if ($urandom_range(19) == 0)
      send_event(EV_SYNC, CODE_W'($urandom_range(1023, 1)), $urandom(), 1'b0);
    if ($urandom_range(9) != 0)
      send_event(EV_SYNC, CODE_SYNC_REPORT, $urandom(), 1'b1);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    evt.valid       = 1'b0;
    evt.event_type  = '0;
    evt.event_code  = '0;
    evt.event_value = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // spare indexes must not disturb the defaults
    write_reg(CFG_IDX_SPARE_A, '1);
    write_reg(CFG_IDX_SPARE_B, '1);
    cfg_we_i <= 1'b0;

    // directed: default mapping, pixel equals raw
    send_event(EV_SYNC, CODE_SYNC_REPORT, '0, 1'b0);
    send_event(EV_ABS, CODE_SLOT, 3, 1'b0);
    send_event(EV_ABS, CODE_TRACK_ID, 5, 1'b0);
    send_event(EV_ABS, CODE_POS_X, 100, 1'b0);
    send_event(EV_ABS, CODE_POS_Y, 200, 1'b0);
    send_event(EV_SYNC, CODE_SYNC_REPORT, '1, 1'b0);
    send_event(EV_ABS, CODE_POS_X, -5, 1'b0);
    send_event(EV_ABS, CODE_POS_Y, 70000, 1'b0);
    send_event(EV_SYNC, CODE_SYNC_REPORT, '0, 1'b0);
    send_event(EV_ABS, CODE_SLOT, -7, 1'b0);
    send_event(EV_ABS, CODE_TRACK_ID, 0, 1'b0);
    send_event(EV_SYNC, CODE_SYNC_REPORT, '0, 1'b0);
    send_event(EV_ABS, CODE_SLOT, 32'h7fff_ffff, 1'b0);
    send_event(EV_ABS, CODE_TRACK_ID, 32'h8000_0000, 1'b0);
    send_event(EV_ABS, CODE_POS_X, 32'h7fff_ffff, 1'b0);
    send_event(EV_ABS, CODE_POS_Y, 32'h8000_0000, 1'b0);
    send_event(EV_ABS, CODE_SLOT, 0, 1'b0);
    send_event(EV_ABS, CODE_TRACK_ID, TRACK_LIFT, 1'b0);
    send_event(EV_SYNC, CODE_SYNC_REPORT, '0, 1'b0);
    send_event(EV_ABS, CODE_SLOT, FINGER_SLOTS - 1, 1'b0);
    send_event(EV_ABS, CODE_TRACK_ID, TRACK_LIFT, 1'b0);
    send_event(EV_SYNC, CODE_UNKNOWN, '1, 1'b0);
    send_event(EV_UNKNOWN, CODE_UNKNOWN, '1, 1'b0);
    send_event(EV_ABS, CODE_UNKNOWN, '0, 1'b0);
    send_event(EV_SYNC, CODE_SYNC_REPORT, '0, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_reports();
      program_phase(ph);
      while (items_sent < (ph + 1) * RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(39) == 0) drain_reports();
        send_frame();
      end
    end

    drain_reports();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
